/* src/abct_pkg.sv */
package abct_pkg;

  localparam int PEERS = 2;
  localparam int ENTRY_MAX = 8;
  localparam int SLOT_W = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CNT_W = $clog2(ENTRY_MAX + 1);
  localparam int ADDR_W = (PEERS * ENTRY_MAX > 1) ? $clog2(PEERS * ENTRY_MAX) : 1;
  localparam int USE_W = $clog2(PEERS + 1);
  localparam int ENT_W = 32 + 16 + 32;

  typedef enum logic [1:0] {
    FN_QUEUE = 2'd0,
    FN_FWD   = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_ADDED      = 4'd0,
    ST_REPLACED   = 4'd1,
    ST_DUP        = 4'd2,
    ST_SUPPRESSED = 4'd3,
    ST_BATCH_FULL = 4'd4,
    ST_TABLE_FULL = 4'd5,
    ST_BAD_ARG    = 4'd6,
    ST_NOT_FOUND  = 4'd7,
    ST_CLEARED    = 4'd8,
    ST_ENTRY      = 4'd9,
    ST_FWD        = 4'd10
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POST,
    S_SCAN,
    S_RDWAIT,
    S_EMIT,
    S_OUT
  } state_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic single;     // request ends with one result decided at lookup
    logic do_read;    // read request walks the entries
    logic scan_done;  // scan index reached the count
    logic dup_hit;    // registered entry matches
  } dp_stat_t;

  // Controller commands toward the datapath.
  typedef struct packed {
    logic load;       // capture request
    logic decide;     // evaluate slot lookup, apply slot updates
    logic scan_adv;   // advance index
    logic append;     // write new entry and bump count unless batch full, load result
    logic out_single; // load output with the decided status
    logic out_dup;    // load output with duplicate status
    logic out_entry;  // load output with entry
  } dp_cmd_t;

endpackage

/* src/abct_ram.sv */
module abct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/abct_ctrl.sv */
module abct_ctrl import abct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.single) begin
          state_next = S_POST;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_POST: begin
        // slot updates have landed; load the result
        cmd.out_single = 1'b1;
        state_next = S_OUT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.do_read) begin
            state_next = S_IDLE;
          end else begin
            cmd.append = 1'b1;
            state_next = S_OUT;
          end
        end else begin
          state_next = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.do_read) begin
          cmd.out_entry = 1'b1;
          cmd.scan_adv = 1'b1;
          state_next = S_OUT;
        end else if (stat.dup_hit) begin
          cmd.out_dup = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_OUT: begin
        if (out_valid && !out_stall) begin
          state_next = (stat.do_read && !stat.scan_done) ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/abct_dpath.sv */
module abct_dpath import abct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  func,
  input  logic [63:0] peer,
  input  logic [1:0]  msg_kind,
  input  logic [63:0] dest_node,
  input  logic [31:0] sess,
  input  logic [15:0] seq_num,
  input  logic [31:0] pkt_ident,
  input  logic        pkt_ident_present,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [3:0]  status,
  output logic [31:0] out_sess,
  output logic [15:0] out_seq_num,
  output logic [31:0] out_pkt_ident,
  output logic        out_msg_kind,
  output logic [63:0] out_dest_node,
  output logic        last,
  output logic [1:0]  peers_in_use
);

  logic [1:0]  r_func;
  logic [63:0] r_peer;
  logic [1:0]  r_kind;
  logic [63:0] r_dest;
  logic [31:0] r_sess;
  logic [15:0] r_seq;
  logic [31:0] r_pkt;

  logic [PEERS-1:0] slot_valid;
  logic [63:0]      slot_peer [PEERS];
  logic [PEERS-1:0] slot_forwarded;
  logic [PEERS-1:0] slot_kind;
  logic [63:0]      slot_dest [PEERS];
  logic [CNT_W-1:0] slot_count [PEERS];

  logic [SLOT_W-1:0] sel;
  logic [CNT_W-1:0]  idx;
  logic [3:0]        pre_status;
  logic              do_read;

  logic             hit, free_ok;
  logic [SLOT_W-1:0] hit_s, free_s, tgt;
  logic [USE_W-1:0] used;

  logic             q_single, q_rebuild, q_full;
  logic [3:0]       q_status;
  logic             add_ok, fwd_ok, clr_ok, batch_full, show_slot;
  logic [3:0]       res_status;

  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;

  always_comb begin
    hit = 1'b0;
    hit_s = '0;
    free_ok = 1'b0;
    free_s = '0;
    used = '0;
    for (int i = PEERS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_peer[i] == r_peer && r_peer != 64'd0) begin
        hit = 1'b1;
        hit_s = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free_ok = 1'b1;
        free_s = SLOT_W'(i);
      end
    end
    for (int i = 0; i < PEERS; i++) begin
      used = used + USE_W'(slot_valid[i]);
    end
    tgt = hit ? hit_s : free_s;
  end

  // Lookup outcome of the registered request
  always_comb begin
    q_full = !hit && !free_ok;
    q_rebuild = !hit || slot_forwarded[hit_s] || (slot_kind[hit_s] != r_kind[0]) ||
                (slot_dest[hit_s] != r_dest);
    q_single = 1'b1;
    q_status = ST_BAD_ARG;
    case (r_func)
      FN_QUEUE: begin
        if (r_peer == 64'd0 || r_kind > 2'd1) begin
          q_status = ST_BAD_ARG;
        end else if (q_full) begin
          q_status = ST_TABLE_FULL;
        end else if (hit && slot_forwarded[hit_s] && !slot_kind[hit_s] &&
                     r_kind == 2'd1 && slot_dest[hit_s] == r_dest) begin
          q_status = ST_SUPPRESSED;
        end else begin
          q_single = 1'b0;
          q_status = (hit && q_rebuild) ? ST_REPLACED : ST_ADDED;
        end
      end
      FN_FWD: begin
        if (r_peer == 64'd0 || r_kind != 2'd0) begin
          q_status = ST_BAD_ARG;
        end else if (q_full) begin
          q_status = ST_TABLE_FULL;
        end else begin
          q_status = hit ? ST_REPLACED : ST_ADDED;
        end
      end
      FN_READ: begin
        if (r_peer == 64'd0) begin
          q_status = ST_BAD_ARG;
        end else if (!hit || slot_count[hit_s] == '0) begin
          q_status = ST_NOT_FOUND;
        end else if (slot_forwarded[hit_s]) begin
          q_status = ST_FWD;
        end else begin
          q_single = 1'b0;
          q_status = ST_ENTRY;
        end
      end
      default: begin
        q_status = hit ? ST_CLEARED : ST_NOT_FOUND;
      end
    endcase
  end

  assign add_ok = (r_func == FN_QUEUE) && !q_single;
  assign fwd_ok = (r_func == FN_FWD) && (r_peer != 64'd0) && (r_kind == 2'd0) && !q_full;
  assign clr_ok = (r_func == FN_CLEAR) && hit;
  assign batch_full = (slot_count[sel] >= CNT_W'(ENTRY_MAX));

  abct_ram #(.WIDTH(ENT_W), .DEPTH(PEERS * ENTRY_MAX)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = ADDR_W'(sel * ENTRY_MAX) + ADDR_W'(idx);

  always_comb begin
    we = 1'b0;
    waddr = ADDR_W'(sel * ENTRY_MAX) + ADDR_W'(slot_count[sel]);
    wdata = {r_sess, r_seq, r_pkt};
    if (cmd.decide && fwd_ok) begin
      we = 1'b1;
      waddr = ADDR_W'(tgt * ENTRY_MAX);
      wdata = '0;
    end else if (cmd.append && !batch_full) begin
      we = 1'b1;
    end
  end

  assign stat.single = q_single;
  assign stat.do_read = do_read;
  assign stat.scan_done = (idx == slot_count[sel]);
  assign stat.dup_hit = (rdata[ENT_W-1 -: 48] == {r_sess, r_seq});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func;
      r_peer <= peer;
      r_kind <= msg_kind;
      r_dest <= dest_node;
      r_sess <= sess;
      r_seq  <= seq_num;
      r_pkt  <= pkt_ident_present ? pkt_ident : 32'd0;
    end
  end

  // Lookup and slot updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_forwarded <= '0;
      slot_kind <= '0;
      do_read <= 1'b0;
      for (int i = 0; i < PEERS; i++) begin
        slot_peer[i] <= '0;
        slot_dest[i] <= '0;
        slot_count[i] <= '0;
      end
      sel <= '0;
      idx <= '0;
      pre_status <= ST_ADDED;
    end else begin
      if (cmd.load) begin
        do_read <= 1'b0;
        idx <= '0;
      end
      if (cmd.scan_adv) begin
        idx <= idx + 1'b1;
      end
      if (cmd.append && !batch_full) begin
        slot_count[sel] <= slot_count[sel] + 1'b1;
      end
      if (cmd.decide) begin
        sel <= tgt;
        pre_status <= q_status;
        do_read <= (r_func == FN_READ) && !q_single;
        if (add_ok && q_rebuild) begin
          slot_valid[tgt] <= 1'b1;
          slot_peer[tgt] <= r_peer;
          slot_kind[tgt] <= r_kind[0];
          slot_dest[tgt] <= r_dest;
          slot_forwarded[tgt] <= 1'b0;
          slot_count[tgt] <= '0;
        end
        if (fwd_ok) begin
          slot_valid[tgt] <= 1'b1;
          slot_peer[tgt] <= r_peer;
          slot_kind[tgt] <= 1'b0;
          slot_dest[tgt] <= r_dest;
          slot_forwarded[tgt] <= 1'b1;
          slot_count[tgt] <= CNT_W'(1);
        end
        if (clr_ok) begin
          slot_valid[tgt] <= 1'b0;
          slot_peer[tgt] <= '0;
          slot_kind[tgt] <= 1'b0;
          slot_dest[tgt] <= '0;
          slot_forwarded[tgt] <= 1'b0;
          slot_count[tgt] <= '0;
        end
      end
    end
  end

  always_comb begin
    if (cmd.out_dup) begin
      res_status = ST_DUP;
    end else if (cmd.append) begin
      res_status = batch_full ? ST_BATCH_FULL : pre_status;
    end else begin
      res_status = pre_status;
    end
  end

  assign show_slot = cmd.out_single && (pre_status == ST_FWD);

  // Output register; held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.out_dup || cmd.append || cmd.out_entry) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_entry) begin
      status <= ST_ENTRY;
      out_sess <= rdata[ENT_W-1 -: 32];
      out_seq_num <= rdata[47:32];
      out_pkt_ident <= rdata[31:0];
      out_msg_kind <= slot_kind[sel];
      out_dest_node <= slot_dest[sel];
      last <= (idx + 1'b1 == slot_count[sel]);
      peers_in_use <= 2'(used);
    end else if (cmd.out_single || cmd.out_dup || cmd.append) begin
      status <= res_status;
      out_sess <= '0;
      out_seq_num <= '0;
      out_pkt_ident <= '0;
      out_msg_kind <= show_slot ? slot_kind[sel] : 1'b0;
      out_dest_node <= show_slot ? slot_dest[sel] : 64'd0;
      last <= 1'b1;
      peers_in_use <= 2'(used);
    end
  end

endmodule

/* src/ack_batch_coalescing_table_unit.sv */
// Channel | Signals                                            | Direction
// request | in_valid, in_stall, func, peer, msg_kind, dest_node,| into block
//         | sess, seq_num, pkt_ident, pkt_ident_present        |
// result  | out_valid, out_stall, status, out_sess, ...        | out of block
//
// One request at a time; in_stall stays high until its last result is taken.
// A single-result request passes through S_DECIDE, S_POST and S_OUT before the next
// acceptance. A queue request checks stored entries one at a time through the entry
// RAM's registered read port (S_SCAN, S_RDWAIT, S_EMIT per entry, up to ENTRY_MAX).
// A read emits one result per entry, each held in the output register while out_stall
// is high. Reset (rst, synchronous) empties all slots; the entry RAM is not cleared.
module ack_batch_coalescing_table_unit import abct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] peer,
  input  logic [1:0]  msg_kind,
  input  logic [63:0] dest_node,
  input  logic [31:0] sess,
  input  logic [15:0] seq_num,
  input  logic [31:0] pkt_ident,
  input  logic        pkt_ident_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [31:0] out_sess,
  output logic [15:0] out_seq_num,
  output logic [31:0] out_pkt_ident,
  output logic        out_msg_kind,
  output logic [63:0] out_dest_node,
  output logic        last,
  output logic [1:0]  peers_in_use
);

  dp_stat_t stat;
  dp_cmd_t  cmd;

  abct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  abct_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(func), .peer(peer), .msg_kind(msg_kind), .dest_node(dest_node),
    .sess(sess), .seq_num(seq_num), .pkt_ident(pkt_ident),
    .pkt_ident_present(pkt_ident_present), .out_stall(out_stall),
    .out_valid(out_valid), .status(status), .out_sess(out_sess),
    .out_seq_num(out_seq_num), .out_pkt_ident(out_pkt_ident),
    .out_msg_kind(out_msg_kind), .out_dest_node(out_dest_node),
    .last(last), .peers_in_use(peers_in_use)
  );

`ifndef NO_ASSERTIONS
  // Never take a new request while a result is still waiting.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request accepted with result pending");
  // Only entry results may carry a clear last bit.
  a_last_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == ST_ENTRY)) else $error("non-final non-entry");
`endif

endmodule
